@@ hw/rtl/ulcpa_pkg.sv @@
// Package: shared constants, types and the DFT length table for the PRB allocator.
`timescale 1ns / 1ps

package ulcpa_pkg;

  localparam int MAX_PRB_DEF = 100;
  localparam int FLD_W       = 7;
  localparam int POS_W       = 8;

  localparam logic [FLD_W-1:0] ACTIVE_PRBS_RST = 7'd100;
  localparam logic [POS_W-1:0] EDGE_GUARD      = 8'd3;

  localparam logic [1:0] ACT_CLEAR   = 2'd0;
  localparam logic [1:0] ACT_RESERVE = 2'd1;
  localparam logic [1:0] ACT_RETX    = 2'd2;
  localparam logic [1:0] ACT_NEW     = 2'd3;

  localparam logic [1:0] ST_GRANTED = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_CLEARED = 2'd2;

  typedef struct packed {
    logic             clear;
    logic             set;
    logic [POS_W-1:0] pos;
  } map_cmd_t;

  // bit n set when n = 2^a * 3^b * 5^c
  function automatic logic [127:0] dft_mask_f();
    logic [127:0] mask;
    int           m;
    mask = '0;
    for (int n = 1; n < 128; n++) begin
      m = n;
      for (int k = 0; k < 7; k++) if (m % 2 == 0) m = m / 2;
      for (int k = 0; k < 5; k++) if (m % 3 == 0) m = m / 3;
      for (int k = 0; k < 4; k++) if (m % 5 == 0) m = m / 5;
      mask[n] = (m == 1);
    end
    return mask;
  endfunction

  localparam logic [127:0] DFT_MASK = dft_mask_f();

endpackage

@@ hw/rtl/ulcpa_map.sv @@
// Used-block bitmap: one bit per resource block, single read/set port, whole-map clear.
`timescale 1ns / 1ps

module ulcpa_map #(
  parameter int MAX_PRB = ulcpa_pkg::MAX_PRB_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ulcpa_pkg::map_cmd_t cmd,
  output logic                rd_used
);
  import ulcpa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PRB);

  logic [MAX_PRB-1:0] used_map;
  logic [IDX_W-1:0]   idx;
  logic               in_range;

  assign idx      = cmd.pos[IDX_W-1:0];
  assign in_range = (cmd.pos < POS_W'(MAX_PRB));
  assign rd_used  = in_range ? used_map[idx] : 1'b1;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      used_map <= '0;
    end else if (cmd.set && in_range) begin
      used_map[idx] <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/ulcpa_seq.sv @@
// Sequencer: range check, run search, DFT trim and marking, one block per cycle.
`timescale 1ns / 1ps

module ulcpa_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  action,
  input  logic [ulcpa_pkg::FLD_W-1:0] range_start,
  input  logic [ulcpa_pkg::FLD_W-1:0] range_length,
  input  logic [ulcpa_pkg::POS_W-1:0] size,
  input  logic                        rd_used,
  output ulcpa_pkg::map_cmd_t         cmd,
  output logic                        busy,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [ulcpa_pkg::FLD_W-1:0] grant_start,
  output logic [ulcpa_pkg::FLD_W-1:0] grant_length
);
  import ulcpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SEARCH = 5'b00100,
    S_TRIM   = 5'b01000,
    S_MARK   = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] end_pos, end_pos_next;
  logic [FLD_W-1:0] run_start, run_start_next;
  logic [FLD_W-1:0] run_len, run_len_next;
  logic [FLD_W-1:0] want, want_next;
  logic [FLD_W-1:0] rstart, rstart_next;
  logic [1:0]       act, act_next;

  logic             fin;
  logic [1:0]       fin_st;
  logic [FLD_W-1:0] fin_start, fin_len;
  logic [POS_W-1:0] span;

  assign span = {1'b0, range_start} + {1'b0, range_length};
  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    end_pos_next   = end_pos;
    run_start_next = run_start;
    run_len_next   = run_len;
    want_next      = want;
    rstart_next    = rstart;
    act_next       = act;
    fin            = 1'b0;
    fin_st         = ST_NOSPACE;
    fin_start      = '0;
    fin_len        = '0;
    cmd            = '0;
    cmd.pos        = pos;
    case (state)
      S_IDLE: begin
        if (start) begin
          act_next       = action;
          want_next      = range_length;
          rstart_next    = range_start;
          run_len_next   = '0;
          run_start_next = '0;
          pos_next       = '0;
          if (action == ACT_CLEAR) begin
            cmd.clear = 1'b1;
            fin       = 1'b1;
            fin_st    = ST_CLEARED;
          end else if (range_length == '0) begin
            fin = 1'b1;
          end else if (action == ACT_NEW) begin
            state_next = S_SEARCH;
          end else if (span > size) begin
            if (action == ACT_RESERVE) fin = 1'b1;
            else state_next = S_SEARCH;
          end else begin
            pos_next     = {1'b0, range_start};
            end_pos_next = span;
            state_next   = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (pos == end_pos) begin
          run_start_next = rstart;
          run_len_next   = want;
          pos_next       = {1'b0, rstart};
          state_next     = S_MARK;
        end else if (rd_used) begin
          if (act == ACT_RESERVE) begin
            fin = 1'b1;
          end else begin
            pos_next   = '0;
            state_next = S_SEARCH;
          end
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end
      S_SEARCH: begin
        if (pos >= size || run_len >= want) begin
          state_next = S_TRIM;
        end else if (!rd_used) begin
          if (run_len == '0) run_start_next = pos[FLD_W-1:0];
          run_len_next = run_len + FLD_W'(1);
          pos_next     = pos + POS_W'(1);
        end else if (run_len != '0) begin
          if (pos < EDGE_GUARD) begin
            run_len_next   = '0;
            run_start_next = '0;
            pos_next       = pos + POS_W'(1);
          end else begin
            state_next = S_TRIM;
          end
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end
      S_TRIM: begin
        if (run_len == '0) begin
          fin = 1'b1;
        end else if (!DFT_MASK[run_len]) begin
          run_len_next = run_len - FLD_W'(1);
        end else if (act == ACT_RETX && run_len != want) begin
          fin = 1'b1;
        end else begin
          pos_next     = {1'b0, run_start};
          end_pos_next = {1'b0, run_start} + {1'b0, run_len};
          state_next   = S_MARK;
        end
      end
      S_MARK: begin
        if (pos == end_pos) begin
          fin       = 1'b1;
          fin_st    = ST_GRANTED;
          fin_start = run_start;
          fin_len   = run_len;
        end else begin
          cmd.set  = 1'b1;
          pos_next = pos + POS_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) state_next = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    end_pos   <= end_pos_next;
    run_start <= run_start_next;
    run_len   <= run_len_next;
    want      <= want_next;
    rstart    <= rstart_next;
    act       <= act_next;
    if (fin) begin
      status       <= fin_st;
      grant_start  <= fin_start;
      grant_length <= fin_len;
    end
  end

endmodule

@@ hw/rtl/ul_contiguous_prb_allocator.sv @@
// Top level: uplink contiguous PRB allocator with carrier-size register.
// Clear and zero-length requests finish from idle; a reserve checks each block
// of its range, then marks it; a search scans for a free run and trims it before marking.
// One block of the map is read or set per cycle; busy stays high until the result.
// Throughput: one item at a time, next item accepted in the cycle of the done strobe.
// Reset (sync, active high): map all free, active_prbs 100, idle; done cannot be stalled.
`timescale 1ns / 1ps

module ul_contiguous_prb_allocator #(
  parameter int MAX_PRB = ulcpa_pkg::MAX_PRB_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ulcpa_pkg::FLD_W-1:0] cfg_wdata,
  input  logic                        start,
  input  logic [1:0]                  action,
  input  logic [ulcpa_pkg::FLD_W-1:0] range_start,
  input  logic [ulcpa_pkg::FLD_W-1:0] range_length,
  output logic                        busy,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [ulcpa_pkg::FLD_W-1:0] grant_start,
  output logic [ulcpa_pkg::FLD_W-1:0] grant_length
);
  import ulcpa_pkg::*;

  logic [FLD_W-1:0] active_prbs;
  logic [POS_W-1:0] size;
  map_cmd_t         cmd;
  logic             rd_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_prbs <= ACTIVE_PRBS_RST;
    end else if (cfg_we) begin
      active_prbs <= cfg_wdata;
    end
  end

  assign size = ({1'b0, active_prbs} > POS_W'(MAX_PRB)) ? POS_W'(MAX_PRB)
                                                        : {1'b0, active_prbs};

  ulcpa_map #(
    .MAX_PRB(MAX_PRB)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_used (rd_used)
  );

  ulcpa_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .action       (action),
    .range_start  (range_start),
    .range_length (range_length),
    .size         (size),
    .rd_used      (rd_used),
    .cmd          (cmd),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .grant_start  (grant_start),
    .grant_length (grant_length)
  );

endmodule

@@ hw/rtl/ulcpa_checker.sv @@
// Port-level checks for the PRB allocator, bound to the top level.
`timescale 1ns / 1ps

module ulcpa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [1:0]                  status,
  input logic [ulcpa_pkg::FLD_W-1:0] grant_start,
  input logic [ulcpa_pkg::FLD_W-1:0] grant_length
);
  import ulcpa_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither worked on nor answered");

  a_nogrant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_GRANTED) |-> (grant_start == '0 && grant_length == '0))
    else $error("non-granted result carries a range");

  a_grant_len: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_GRANTED) |-> (grant_length != '0))
    else $error("empty grant");

endmodule

bind ul_contiguous_prb_allocator ulcpa_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .grant_start  (grant_start),
  .grant_length (grant_length)
);

@@ bench/ul_contiguous_prb_allocator_tb.sv @@
// Testbench: directed and random request streams checked against a PRB map predictor.
`timescale 1ns / 1ps

module ul_contiguous_prb_allocator_tb;
  import ulcpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_SIZE = 180;

  typedef struct packed {
    logic [1:0]       status;
    logic [FLD_W-1:0] gstart;
    logic [FLD_W-1:0] glen;
  } grant_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [FLD_W-1:0] cfg_wdata = '0;
  logic             start = 1'b0;
  logic [1:0]       action = ACT_CLEAR;
  logic [FLD_W-1:0] range_start = '0;
  logic [FLD_W-1:0] range_length = '0;
  logic             busy;
  logic             done;
  logic [1:0]       status;
  logic [FLD_W-1:0] grant_start;
  logic [FLD_W-1:0] grant_length;

  logic [MAX_PRB_DEF-1:0] prb_used = '0;
  logic [FLD_W-1:0]       carrier_prbs_reg = ACTIVE_PRBS_RST;
  grant_t                 expected_grants[$];
  int                     gap_max = 3;
  int                     items_sent = 0;
  int                     results_seen = 0;
  int                     grants_seen = 0;
  int                     clears_seen = 0;
  int                     carrier_writes = 0;
  int                     mismatches = 0;

  ul_contiguous_prb_allocator #(
    .MAX_PRB(MAX_PRB_DEF)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .action(action),
    .range_start(range_start),
    .range_length(range_length),
    .busy(busy),
    .done(done),
    .status(status),
    .grant_start(grant_start),
    .grant_length(grant_length)
  );

  always #6 clk = ~clk;

  function automatic int carrier_prbs();
    return (carrier_prbs_reg < MAX_PRB_DEF) ? int'(carrier_prbs_reg) : MAX_PRB_DEF;
  endfunction

  function automatic bit sc_fdma_len_ok(input int n);
    int m;
    if (n <= 0) return 1'b0;
    m = n;
    while (m % 2 == 0) m = m / 2;
    while (m % 3 == 0) m = m / 3;
    while (m % 5 == 0) m = m / 5;
    return m == 1;
  endfunction

  function automatic bit blocks_free(input int s, input int l, input int sz);
    if (s + l > sz) return 1'b0;
    for (int i = s; i < s + l; i++) begin
      if (prb_used[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void take_blocks(input int s, input int l);
    for (int i = s; i < s + l; i++) prb_used[i] = 1'b1;
  endfunction

  // first free run up to want blocks, edge runs dropped, trimmed to a valid count
  function automatic bit first_free_run(input int want, input int sz,
                                        output int rs, output int rl);
    int s;
    int l;
    s = 0;
    l = 0;
    for (int n = 0; n < sz && l < want; n++) begin
      if (!prb_used[n]) begin
        if (l == 0) s = n;
        l++;
      end else if (l > 0) begin
        if (n < int'(EDGE_GUARD)) begin
          s = 0;
          l = 0;
        end else begin
          break;
        end
      end
    end
    if (l == 0) begin
      rs = 0;
      rl = 0;
      return 1'b0;
    end
    while (!sc_fdma_len_ok(l)) l--;
    rs = s;
    rl = l;
    return l == want;
  endfunction

  function automatic grant_t predict_grant(input logic [1:0] act, input logic [FLD_W-1:0] rs,
                                           input logic [FLD_W-1:0] rl);
    grant_t g;
    int     sz;
    int     fs;
    int     fl;
    g.status = ST_NOSPACE;
    g.gstart = '0;
    g.glen = '0;
    sz = carrier_prbs();
    if (act == ACT_CLEAR) begin
      prb_used = '0;
      g.status = ST_CLEARED;
    end else if (rl == 0) begin
      g.status = ST_NOSPACE;
    end else if ((act == ACT_RESERVE || act == ACT_RETX) && blocks_free(rs, rl, sz)) begin
      take_blocks(rs, rl);
      g.status = ST_GRANTED;
      g.gstart = rs;
      g.glen = rl;
    end else if (act == ACT_RETX) begin
      if (first_free_run(rl, sz, fs, fl)) begin
        take_blocks(fs, fl);
        g.status = ST_GRANTED;
        g.gstart = FLD_W'(fs);
        g.glen = FLD_W'(fl);
      end
    end else if (act == ACT_NEW) begin
      void'(first_free_run(rl, sz, fs, fl));
      if (fl > 0) begin
        take_blocks(fs, fl);
        g.status = ST_GRANTED;
        g.gstart = FLD_W'(fs);
        g.glen = FLD_W'(fl);
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // start stays high across back-to-back items; lowered here for a gap and by wait_settled
  task automatic send_request(input logic [1:0] act, input logic [FLD_W-1:0] rs,
                              input logic [FLD_W-1:0] rl);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    range_start <= rs;
    range_length <= rl;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_grants.push_back(predict_grant(act, rs, rl));
    items_sent++;
  endtask

  task automatic wait_settled();
    start <= 1'b0;
    @(posedge clk);
    while (expected_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_carrier(input logic [FLD_W-1:0] prbs);
    wait_settled();
    cfg_we <= 1'b1;
    cfg_wdata <= prbs;
    carrier_prbs_reg = prbs;
    carrier_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // subframes: mostly clear then well-formed requests, some raw noise
  task automatic run_subframes(input int n);
    int         sent;
    int         sz;
    int         cap;
    int         l;
    int         s;
    int         k;
    logic [1:0] act;
    sent = 0;
    while (sent < n) begin
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
      if ($urandom_range(0, 4) != 0) begin
        send_request(ACT_CLEAR, FLD_W'($urandom), FLD_W'($urandom));
        sent++;
      end
      k = $urandom_range(3, 16);
      repeat (k) begin
        sz = carrier_prbs();
        cap = (sz < 1) ? 1 : sz;
        if ($urandom_range(0, 9) == 0) begin
          send_request(2'($urandom), FLD_W'($urandom), FLD_W'($urandom));
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: l = $urandom_range(1, (cap < 16) ? cap : 16);
            7, 8:                l = $urandom_range(1, cap);
            default:             l = $urandom_range(1, MAX_PRB_DEF);
          endcase
          s = (sz > l) ? $urandom_range(0, sz - l) : 0;
          case ($urandom_range(0, 2))
            0:       act = ACT_RESERVE;
            1:       act = ACT_RETX;
            default: act = ACT_NEW;
          endcase
          send_request(act, FLD_W'(s), FLD_W'(l));
        end
        sent++;
      end
    end
  endtask

  task automatic test_directed_requests();
    gap_max = 3;
    send_request(ACT_CLEAR, 7'd127, 7'd127);
    send_request(ACT_RESERVE, 7'd10, 7'd0);
    send_request(ACT_RETX, 7'd10, 7'd0);
    send_request(ACT_NEW, 7'd0, 7'd0);
    send_request(ACT_RESERVE, 7'd99, 7'd1);
    send_request(ACT_RESERVE, 7'd99, 7'd2);
    send_request(ACT_RESERVE, 7'd127, 7'd127);
    send_request(ACT_RESERVE, 7'd0, 7'd2);
    send_request(ACT_NEW, 7'd0, 7'd127);
    send_request(ACT_NEW, 7'd0, 7'd5);
    send_request(ACT_NEW, 7'd0, 7'd1);
    send_request(ACT_CLEAR, 7'd0, 7'd0);
    // used block 1 drops the run at block 0
    send_request(ACT_RESERVE, 7'd1, 7'd1);
    send_request(ACT_NEW, 7'd0, 7'd10);
    // old range reused with a length that is not a valid count
    send_request(ACT_RETX, 7'd20, 7'd7);
    send_request(ACT_RETX, 7'd20, 7'd7);
    send_request(ACT_RETX, 7'd20, 7'd6);
    send_request(ACT_RESERVE, 7'd0, 7'd1);
    send_request(ACT_NEW, 7'd0, 7'd100);
    send_request(ACT_CLEAR, 7'd0, 7'd0);
    send_request(ACT_RESERVE, 7'd0, 7'd100);
    send_request(ACT_RETX, 7'd0, 7'd100);
    send_request(ACT_NEW, 7'd0, 7'd3);
    send_request(ACT_CLEAR, 7'd0, 7'd0);
    send_request(ACT_RESERVE, 7'd2, 7'd1);
    send_request(ACT_NEW, 7'd0, 7'd4);
  endtask

  task automatic test_carrier_extremes();
    logic [FLD_W-1:0] sizes[5];
    sizes = '{7'd6, 7'd127, 7'd0, 7'd1, 7'd5};
    foreach (sizes[i]) begin
      write_carrier(sizes[i]);
      run_subframes(ITEMS_PER_SIZE);
    end
  endtask

  task automatic test_random_carriers();
    logic [FLD_W-1:0] sizes[3];
    sizes = '{7'd99, FLD_W'($urandom_range(7, 98)), 7'd100};
    foreach (sizes[i]) begin
      write_carrier(sizes[i]);
      run_subframes(ITEMS_PER_SIZE);
    end
  endtask

  always @(posedge clk) begin : result_check
    grant_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_grants.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_grants.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (grant_start !== want.gstart)
          report_mismatch($sformatf("grant_start %0d, expected %0d", grant_start, want.gstart));
        if (grant_length !== want.glen)
          report_mismatch($sformatf("grant_length %0d, expected %0d", grant_length, want.glen));
        if (want.status == ST_GRANTED) grants_seen++;
        if (want.status == ST_CLEARED) clears_seen++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || done || (start && !busy)) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("ul_contiguous_prb_allocator regression: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_requests();
    test_carrier_extremes();
    test_random_carriers();
    wait_settled();
    repeat (20) @(posedge clk);
    $display("%0d items sent, %0d results checked: %0d granted, %0d clears",
             items_sent, results_seen, grants_seen, clears_seen);
    $display("%0d carrier sizes written, %0d mismatches", carrier_writes, mismatches);
    if (mismatches == 0) begin
      $display("ul_contiguous_prb_allocator regression: pass");
    end else begin
      $display("ul_contiguous_prb_allocator regression: fail");
    end
    $finish;
  end

endmodule
